// ----- src/hst_pkg.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangulator package
// Shared constants, register indexes, records and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package hst_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned Z_W        = 20;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned DIFF_W     = 21;
  localparam int unsigned SQ_W       = 42;
  localparam int unsigned SUMSQ_W    = 44;
  localparam int unsigned RAD_W      = 60;
  localparam int unsigned ROOT_W     = 30;
  localparam int unsigned REM_W      = 34;
  localparam int unsigned MAG_W      = 29;
  localparam int unsigned NUM_W      = 46;
  localparam int unsigned QUO_W      = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_HEIGHT_GAIN   = 3'd2,
    CFG_HEIGHT_OFFSET = 3'd3,
    CFG_BASE_LEVEL    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [CFG_W-1:0]  gain;
    logic [CFG_W-1:0]  offset;
    logic [CFG_W-1:0]  base;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ys;
    logic [Z_W-1:0]     z_nw;
    logic [Z_W-1:0]     z_ne;
    logic [Z_W-1:0]     z_sw;
    logic [Z_W-1:0]     z_se;
  } cell_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_READ,
    F_UPPER,
    F_ELEV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ_A,
    B_SQ_B,
    B_ROOT,
    B_DIV_LOAD,
    B_DIV,
    B_EMIT
  } back_state_e;

endpackage

`default_nettype wire

// ----- src/hst_if.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangulator channels
// Valid/ready channels for pixel requests and vertex results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hst_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] height;
  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface hst_vertex_if;
  logic               valid;
  logic               ready;
  logic [9:0]         vert_x;
  logic [9:0]         vert_y;
  logic [19:0]        vert_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic               last_of_cell;
  modport source (output valid, output vert_x, output vert_y, output vert_z,
                  output norm_x, output norm_y, output norm_z, output last_of_cell,
                  input ready);
  modport sink (input valid, input vert_x, input vert_y, input vert_z,
                input norm_x, input norm_y, input norm_z, input last_of_cell,
                output ready);
endinterface

`default_nettype wire

// ----- src/hst_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/hst_front.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangulator front end
// Accepts pixels, keeps the line buffer and counters, and builds cell records.
// ----------------------------------------------------------------------------
`default_nettype none

module hst_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hst_pkg::cfg_t  cfg_i,
  input  logic           restart_i,
  hst_pixel_if.sink      pix,
  output hst_pkg::cell_t cell_o,
  output logic           cell_valid_o,
  input  logic           cell_ready_i
);

  import hst_pkg::*;

  front_state_e     state_q, state_d;
  logic [PIX_W-1:0] cur_q, cur_d;
  logic [PIX_W-1:0] left_q, left_d;
  logic [PIX_W-1:0] upleft_q, upleft_d;
  logic [PIX_W-1:0] upper_q, upper_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       corner_q, corner_d;
  logic [Z_W-1:0]   z_q [4];
  logic [Z_W-1:0]   z_d [4];

  logic             ram_we, ram_re;
  logic [PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0] elev_h;
  logic [23:0]      elev_prod;
  logic [17:0]      elev_sum;
  logic             is_cell;
  logic [SIZE_W-1:0] ys_full;

  hst_ram #(.Width(PIX_W), .Depth(MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (cur_q),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (corner_q)
      2'd0: elev_h = upleft_q;
      2'd1: elev_h = upper_q;
      2'd2: elev_h = left_q;
      default: elev_h = cur_q;
    endcase
  end

  assign elev_prod = elev_h * cfg_i.gain;
  assign elev_sum  = (elev_h != '0)
                     ? 18'(cfg_i.base) + 18'(elev_prod[23:8]) + 18'(cfg_i.offset)
                     : 18'(cfg_i.base);

  assign is_cell = (col_q != '0) && (row_q != '0);
  assign ys_full = cfg_i.height - SIZE_W'(row_q) - SIZE_W'(1);

  assign cell_o.xe   = col_q;
  assign cell_o.ys   = ys_full[COORD_W-1:0];
  assign cell_o.z_nw = z_q[0];
  assign cell_o.z_ne = z_q[1];
  assign cell_o.z_sw = z_q[2];
  assign cell_o.z_se = z_q[3];

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    left_d       = left_q;
    upleft_d     = upleft_q;
    upper_d      = upper_q;
    col_d        = col_q;
    row_d        = row_q;
    corner_d     = corner_q;
    z_d          = z_q;
    pix.ready    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    cell_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        pix.ready = 1'b1;
        if (pix.valid) begin
          cur_d   = pix.height;
          state_d = F_READ;
        end
      end
      F_READ: begin
        ram_re  = 1'b1;
        state_d = F_UPPER;
      end
      F_UPPER: begin
        upper_d  = ram_rdata;
        corner_d = 2'd0;
        state_d  = F_ELEV;
      end
      F_ELEV: begin
        z_d[corner_q] = Z_W'(elev_sum);
        corner_d      = corner_q + 2'd1;
        if (corner_q == 2'd3) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        cell_valid_o = is_cell;
        if (!is_cell || cell_ready_i) begin
          ram_we   = 1'b1;
          upleft_d = upper_q;
          left_d   = cur_q;
          if ((SIZE_W'(col_q) + SIZE_W'(1)) >= cfg_i.width) begin
            col_d = '0;
            if ((SIZE_W'(row_q) + SIZE_W'(1)) >= cfg_i.height) begin
              row_d = '0;
            end else begin
              row_d = row_q + ROW_W'(1);
            end
          end else begin
            col_d = col_q + COL_W'(1);
          end
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
    if (restart_i) begin
      col_d    = '0;
      row_d    = '0;
      left_d   = '0;
      upleft_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      left_q   <= '0;
      upleft_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      corner_q <= '0;
    end else begin
      state_q  <= state_d;
      left_q   <= left_d;
      upleft_q <= upleft_d;
      col_q    <= col_d;
      row_q    <= row_d;
      corner_q <= corner_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    upper_q <= upper_d;
    z_q     <= z_d;
  end

endmodule

`default_nettype wire

// ----- src/hst_queue.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangulator cell queue
// Two-entry queue of cell records between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module hst_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hst_pkg::cell_t push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output hst_pkg::cell_t pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  import hst_pkg::*;

  cell_t      entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = do_push ? ~wptr_q : wptr_q;
    rptr_d  = do_pop ? ~rptr_q : rptr_q;
    count_d = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/hst_back.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangulator back end
// Computes triangle normals bit-serially and emits six vertices per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hst_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hst_pkg::cell_t cell_i,
  input  logic           cell_valid_i,
  output logic           cell_ready_o,
  hst_vertex_if.source   vtx
);

  import hst_pkg::*;

  back_state_e              state_q, state_d;
  cell_t                    cell_q, cell_d;
  logic                     tri_q, tri_d;
  logic [SUMSQ_W-1:0]       sumsq_q, sumsq_d;
  logic [RAD_W-1:0]         rad_q, rad_d;
  logic [ROOT_W-1:0]        root_q, root_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [4:0]               step_q, step_d;
  logic [1:0]               comp_q, comp_d;
  logic [NUM_W-1:0]         num_q, num_d;
  logic [NUM_W-1:0]         dsh_q, dsh_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  logic [NORM_W-1:0]        nrm_q [3];
  logic [NORM_W-1:0]        nrm_d [3];
  logic [NORM_W-1:0]        onrm_q [3];
  logic [NORM_W-1:0]        onrm_d [3];
  logic [1:0]               vix_q, vix_d;
  logic                     ovalid_q, ovalid_d;
  logic [COORD_W-1:0]       ox_q, ox_d, oy_q, oy_d;
  logic [Z_W-1:0]           oz_q, oz_d;
  logic                     olast_q, olast_d;

  logic signed [DIFF_W-1:0] diff_a, diff_b, mul_op;
  logic signed [SQ_W-1:0]   prod;
  logic [DIFF_W-1:0]        abs_op;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic [REM_W-1:0]         rem_sh, trial;
  logic                     take;
  logic [QUO_W-1:0]         quo_next;
  logic [COORD_W-1:0]       xw, yn;

  always_comb begin
    if (!tri_q) begin
      diff_a = $signed({1'b0, cell_q.z_sw}) - $signed({1'b0, cell_q.z_se});
      diff_b = $signed({1'b0, cell_q.z_sw}) - $signed({1'b0, cell_q.z_nw});
    end else begin
      diff_a = $signed({1'b0, cell_q.z_nw}) - $signed({1'b0, cell_q.z_ne});
      diff_b = $signed({1'b0, cell_q.z_se}) - $signed({1'b0, cell_q.z_ne});
    end
  end

  assign mul_op = (state_q == B_SQ_A) ? diff_a : diff_b;
  assign prod   = mul_op * mul_op;

  always_comb begin
    unique case (comp_q)
      2'd0: begin
        neg    = diff_a[DIFF_W-1];
        abs_op = neg ? -diff_a : diff_a;
        mag    = MAG_W'({abs_op[DIFF_W-2:0], 8'b0});
      end
      2'd1: begin
        neg    = diff_b[DIFF_W-1];
        abs_op = neg ? -diff_b : diff_b;
        mag    = MAG_W'({abs_op[DIFF_W-2:0], 8'b0});
      end
      default: begin
        neg    = 1'b0;
        abs_op = '0;
        mag    = MAG_W'(65536);
      end
    endcase
  end

  assign rem_sh   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial    = REM_W'({root_q, 2'b01});
  assign take     = (num_q >= dsh_q);
  assign quo_next = {quo_q[QUO_W-2:0], take};
  assign xw       = cell_q.xe - COORD_W'(1);
  assign yn       = cell_q.ys + COORD_W'(1);

  assign vtx.valid        = ovalid_q;
  assign vtx.vert_x       = ox_q;
  assign vtx.vert_y       = oy_q;
  assign vtx.vert_z       = oz_q;
  assign vtx.norm_x       = onrm_q[0];
  assign vtx.norm_y       = onrm_q[1];
  assign vtx.norm_z       = onrm_q[2];
  assign vtx.last_of_cell = olast_q;

  always_comb begin
    state_d      = state_q;
    cell_d       = cell_q;
    tri_d        = tri_q;
    sumsq_d      = sumsq_q;
    rad_d        = rad_q;
    root_d       = root_q;
    rem_d        = rem_q;
    step_d       = step_q;
    comp_d       = comp_q;
    num_d        = num_q;
    dsh_d        = dsh_q;
    quo_d        = quo_q;
    nrm_d        = nrm_q;
    onrm_d       = onrm_q;
    vix_d        = vix_q;
    ox_d         = ox_q;
    oy_d         = oy_q;
    oz_d         = oz_q;
    olast_d      = olast_q;
    ovalid_d     = ovalid_q && !vtx.ready;
    cell_ready_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        cell_ready_o = 1'b1;
        if (cell_valid_i) begin
          cell_d  = cell_i;
          tri_d   = 1'b0;
          state_d = B_SQ_A;
        end
      end
      B_SQ_A: begin
        sumsq_d = SUMSQ_W'(unsigned'(prod)) + SUMSQ_W'(65536);
        state_d = B_SQ_B;
      end
      B_SQ_B: begin
        rad_d   = {sumsq_q + SUMSQ_W'(unsigned'(prod)), 16'b0};
        root_d  = '0;
        rem_d   = '0;
        step_d  = '0;
        state_d = B_ROOT;
      end
      B_ROOT: begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        step_d = step_q + 5'd1;
        if (step_q == 5'(ROOT_W - 1)) begin
          comp_d  = '0;
          state_d = B_DIV_LOAD;
        end
      end
      B_DIV_LOAD: begin
        num_d   = NUM_W'({mag, 15'b0}) + NUM_W'(root_q);
        dsh_d   = NUM_W'({root_q, 15'b0});
        quo_d   = '0;
        step_d  = '0;
        state_d = B_DIV;
      end
      B_DIV: begin
        if (take) begin
          num_d = num_q - dsh_q;
        end
        dsh_d  = {1'b0, dsh_q[NUM_W-1:1]};
        quo_d  = quo_next;
        step_d = step_q + 5'd1;
        if (step_q == 5'(QUO_W - 1)) begin
          nrm_d[comp_q] = neg ? -NORM_W'(quo_next) : NORM_W'(quo_next);
          if (comp_q == 2'd2) begin
            vix_d   = '0;
            state_d = B_EMIT;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = B_DIV_LOAD;
          end
        end
      end
      B_EMIT: begin
        if (!ovalid_q || vtx.ready) begin
          ovalid_d = 1'b1;
          olast_d  = tri_q && (vix_q == 2'd2);
          onrm_d   = nrm_q;
          unique case (vix_q)
            2'd0: begin
              ox_d = xw;
              oy_d = yn;
              oz_d = cell_q.z_nw;
            end
            2'd1: begin
              ox_d = tri_q ? cell_q.xe : xw;
              oy_d = cell_q.ys;
              oz_d = tri_q ? cell_q.z_se : cell_q.z_sw;
            end
            default: begin
              ox_d = cell_q.xe;
              oy_d = tri_q ? yn : cell_q.ys;
              oz_d = tri_q ? cell_q.z_ne : cell_q.z_se;
            end
          endcase
          vix_d = vix_q + 2'd1;
          if (vix_q == 2'd2) begin
            if (!tri_q) begin
              tri_d   = 1'b1;
              state_d = B_SQ_A;
            end else begin
              state_d = B_IDLE;
            end
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      tri_q    <= 1'b0;
      step_q   <= '0;
      comp_q   <= '0;
      vix_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tri_q    <= tri_d;
      step_q   <= step_d;
      comp_q   <= comp_d;
      vix_q    <= vix_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q  <= cell_d;
    sumsq_q <= sumsq_d;
    rad_q   <= rad_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    nrm_q   <= nrm_d;
    onrm_q  <= onrm_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oz_q    <= oz_d;
    olast_q <= olast_d;
  end

endmodule

`default_nettype wire

// ----- src/heightmap_surface_triangulator.sv -----
// ----------------------------------------------------------------------------
// Heightmap surface triangulator
// Turns raster-order heightmap pixels into two triangles per grid cell.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; each pixel that closes a grid cell yields six
// vertex results with the unit normal of their triangle, while pixels in the
// first row or column yield none. In the back end a cell's time is set by the
// bit-serial square root and the bit-serial divider (one pass per normal
// component), which run once per triangle; a two-entry cell queue lets the
// front end take the next pixels meanwhile. Writing the width or the height
// starts a new frame.
`default_nettype none

module heightmap_surface_triangulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hst_pkg::CFG_W-1:0]     cfg_data_i,
  hst_pixel_if.sink                     in_ch,
  hst_vertex_if.source                  out_ch
);

  import hst_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q;
  logic [CFG_W-1:0]  gain_q, offset_q, base_q;
  logic              restart;
  cfg_t              cfg;
  cell_t             push_cell, pop_cell;
  logic              push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(MAX_WIDTH);
      height_q <= SIZE_W'(MAX_HEIGHT);
      gain_q   <= '0;
      offset_q <= '0;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT_GAIN:   gain_q   <= cfg_data_i;
        CFG_HEIGHT_OFFSET: offset_q <= cfg_data_i;
        CFG_BASE_LEVEL:    base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_e'(cfg_idx_i) == CFG_IMAGE_WIDTH) ||
                                (cfg_idx_e'(cfg_idx_i) == CFG_IMAGE_HEIGHT));

  always_comb begin
    if (width_q < SIZE_W'(2)) begin
      cfg.width = SIZE_W'(2);
    end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
      cfg.width = SIZE_W'(MAX_WIDTH);
    end else begin
      cfg.width = width_q;
    end
    if (height_q < SIZE_W'(2)) begin
      cfg.height = SIZE_W'(2);
    end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
      cfg.height = SIZE_W'(MAX_HEIGHT);
    end else begin
      cfg.height = height_q;
    end
    cfg.gain   = gain_q;
    cfg.offset = offset_q;
    cfg.base   = base_q;
  end

  hst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .restart_i    (restart),
    .pix          (in_ch),
    .cell_o       (push_cell),
    .cell_valid_o (push_valid),
    .cell_ready_i (push_ready)
  );

  hst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_cell),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_cell),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  hst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_i       (pop_cell),
    .cell_valid_i (pop_valid),
    .cell_ready_o (pop_ready),
    .vtx          (out_ch)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap surface triangulator testbench
// Streams heightmap pixels under several register settings and handshake
// stall patterns, predicts every vertex with its own model of the block and
// compares each vertex result field by field in order.
// ----------------------------------------------------------------------------

typedef struct {
  logic [9:0]         x;
  logic [9:0]         y;
  logic [19:0]        z;
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  logic               last;
} vertex_t;

typedef longint corner_t[3];

class mesh_scoreboard;
  longint  width_reg, height_reg, gain, offset, base;
  byte unsigned line_buf[1024];
  longint  left_h, upper_left_h, col, row;
  vertex_t vertex_q[$];
  int      errors;

  function new();
    width_reg = 1024;
    height_reg = 1024;
    gain = 0;
    offset = 0;
    base = 0;
    foreach (line_buf[i]) line_buf[i] = 0;
    left_h = 0;
    upper_left_h = 0;
    col = 0;
    row = 0;
    errors = 0;
  endfunction

  function void write_reg(hst_pkg::cfg_idx_e idx, longint value);
    case (idx)
      hst_pkg::CFG_IMAGE_WIDTH:   width_reg = value & 'h7FF;
      hst_pkg::CFG_IMAGE_HEIGHT:  height_reg = value & 'h7FF;
      hst_pkg::CFG_HEIGHT_GAIN:   gain = value & 'hFFFF;
      hst_pkg::CFG_HEIGHT_OFFSET: offset = value & 'hFFFF;
      hst_pkg::CFG_BASE_LEVEL:    base = value & 'hFFFF;
      default: ;
    endcase
    if (idx == hst_pkg::CFG_IMAGE_WIDTH || idx == hst_pkg::CFG_IMAGE_HEIGHT) begin
      col = 0;
      row = 0;
      left_h = 0;
      upper_left_h = 0;
    end
  endfunction

  function longint clamp_size(longint v);
    if (v < 2) return 2;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function longint elevation(longint h);
    longint z;
    z = base;
    if (h != 0) z += ((h * gain) >> 8) + offset;
    if (z > 'hFFFFF) z = 'hFFFFF;
    return z;
  endfunction

  function longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function logic [15:0] unit_comp(longint n, longint unsigned r);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    if (r == 0) return 0;
    q = (mag * 32768 + r) / (2 * r);
    if (n < 0) q = -q;
    return q[15:0];
  endfunction

  function void add_triangle(corner_t a, corner_t b, corner_t c, bit closes);
    longint u[3], w[3], n[3];
    longint unsigned s, r;
    vertex_t v;
    corner_t pts[3];
    for (int i = 0; i < 3; i++) begin
      u[i] = (c[i] - b[i]) * ((i < 2) ? 256 : 1);
      w[i] = (a[i] - b[i]) * ((i < 2) ? 256 : 1);
    end
    n[0] = u[1] * w[2] - u[2] * w[1];
    n[1] = u[2] * w[0] - u[0] * w[2];
    n[2] = u[0] * w[1] - u[1] * w[0];
    s = 0;
    for (int i = 0; i < 3; i++) s += n[i] * n[i];
    r = int_sqrt(s);
    pts[0] = a;
    pts[1] = b;
    pts[2] = c;
    for (int k = 0; k < 3; k++) begin
      v.x = pts[k][0][9:0];
      v.y = pts[k][1][9:0];
      v.z = pts[k][2][19:0];
      v.nx = unit_comp(n[0], r);
      v.ny = unit_comp(n[1], r);
      v.nz = unit_comp(n[2], r);
      v.last = closes && k == 2;
      vertex_q = {vertex_q, v};
    end
  endfunction

  function void note_pixel(logic [7:0] height);
    longint w, hgt, cur, upper;
    corner_t nw, ne, sw, se;
    w = clamp_size(width_reg);
    hgt = clamp_size(height_reg);
    cur = height;
    upper = line_buf[col % 1024];
    if (col >= 1 && row >= 1) begin
      nw = '{col - 1, hgt - row, elevation(upper_left_h)};
      ne = '{col, hgt - row, elevation(upper)};
      sw = '{col - 1, hgt - row - 1, elevation(left_h)};
      se = '{col, hgt - row - 1, elevation(cur)};
      add_triangle(nw, sw, se, 0);
      add_triangle(nw, se, ne, 1);
    end
    upper_left_h = upper;
    left_h = cur;
    line_buf[col % 1024] = cur;
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= hgt) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function void check_vertex(vertex_t got);
    vertex_t exp_v;
    if (vertex_q.size() == 0) begin
      $error("vertex result with none expected");
      errors++;
      return;
    end
    exp_v = vertex_q.pop_front();
    if (got.x !== exp_v.x) begin
      $error("vert_x expected %0d actual %0d", exp_v.x, got.x);
      errors++;
    end
    if (got.y !== exp_v.y) begin
      $error("vert_y expected %0d actual %0d", exp_v.y, got.y);
      errors++;
    end
    if (got.z !== exp_v.z) begin
      $error("vert_z expected %0d actual %0d", exp_v.z, got.z);
      errors++;
    end
    if (got.nx !== exp_v.nx) begin
      $error("norm_x expected %0d actual %0d", exp_v.nx, got.nx);
      errors++;
    end
    if (got.ny !== exp_v.ny) begin
      $error("norm_y expected %0d actual %0d", exp_v.ny, got.ny);
      errors++;
    end
    if (got.nz !== exp_v.nz) begin
      $error("norm_z expected %0d actual %0d", exp_v.nz, got.nz);
      errors++;
    end
    if (got.last !== exp_v.last) begin
      $error("last_of_cell expected %0d actual %0d", exp_v.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb;
  import hst_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  int   idle_mode = 0;
  int   quiet_cycles = 0;
  mesh_scoreboard sb = new();
  vertex_t seen;

  hst_pixel_if  in_ch ();
  hst_vertex_if out_ch ();

  heightmap_surface_triangulator u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.height = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (idle_mode == 2) begin
      out_ch.ready <= ($urandom_range(0, 99) >= 46);
    end else if (idle_mode == 3) begin
      out_ch.ready <= ($urandom_range(0, 99) >= 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) sb.note_pixel(in_ch.height);
    if (out_ch.valid && out_ch.ready) begin
      seen.x = out_ch.vert_x;
      seen.y = out_ch.vert_y;
      seen.z = out_ch.vert_z;
      seen.nx = out_ch.norm_x;
      seen.ny = out_ch.norm_y;
      seen.nz = out_ch.norm_z;
      seen.last = out_ch.last_of_cell;
      sb.check_vertex(seen);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= 20000) begin
      $display("heightmap_surface_triangulator regression: fail");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.vertex_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] h);
    if ((idle_mode == 1 && $urandom_range(0, 99) < 46) ||
        (idle_mode == 3 && $urandom_range(0, 99) < 10)) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.height <= h;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic run_phase(logic [15:0] w, logic [15:0] h, logic [15:0] g, logic [15:0] o,
                           logic [15:0] b, int count);
    byte unsigned px;
    drain();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_HEIGHT_GAIN, g);
    write_reg(CFG_HEIGHT_OFFSET, o);
    write_reg(CFG_BASE_LEVEL, b);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: px = 8'd0;
        1: px = 8'd255;
        default: px = $urandom_range(0, 255);
      endcase
      if (i == count / 2 && count > 20) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        while (sb.vertex_q.size() != 0) @(posedge clk_i);
      end
      send_pixel(px);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    byte unsigned ramp[10] = '{0, 255, 255, 0, 128, 1, 0, 255, 1, 255};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Width and height below range, every term of the elevation at full scale.
    idle_mode = 0;
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    write_reg(CFG_HEIGHT_GAIN, 16'hFFFF);
    write_reg(CFG_HEIGHT_OFFSET, 16'hFFFF);
    write_reg(CFG_BASE_LEVEL, 16'hFFFF);
    foreach (ramp[i]) send_pixel(ramp[i]);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;

    // Flat surface with a height above range; then a first row only, no cells.
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'h07FF);
    write_reg(CFG_HEIGHT_GAIN, 16'd0);
    write_reg(CFG_HEIGHT_OFFSET, 16'd0);
    write_reg(CFG_BASE_LEVEL, 16'd0);
    foreach (ramp[i]) send_pixel(ramp[9 - i]);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_pixel($urandom_range(0, 255));
    @(negedge clk_i);
    in_ch.valid <= 1'b0;

    idle_mode = 1;
    run_phase(16'hF805, 16'd4, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), 50);
    idle_mode = 2;
    run_phase(16'd7, 16'd3, $urandom_range(0, 4095), $urandom_range(0, 65535),
              $urandom_range(0, 65535), 60);
    idle_mode = 3;
    run_phase(16'd4, 16'd1024, $urandom_range(0, 65535), $urandom_range(0, 255),
              $urandom_range(0, 65535), 60);
    idle_mode = 0;
    run_phase(16'd2, 16'd5, 16'hFFFF, $urandom_range(0, 65535), 16'd0, 60);

    drain();
    if (sb.errors == 0) begin
      $display("heightmap_surface_triangulator regression: pass");
    end else begin
      $display("heightmap_surface_triangulator regression: fail");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/hst_pkg.sv
src/hst_if.sv
src/hst_ram.sv
src/hst_front.sv
src/hst_queue.sv
src/hst_back.sv
src/heightmap_surface_triangulator.sv
tb/sv/tb.sv
